// ===== rtl/clb_pkg.sv =====
package clb_pkg;

   // Store geometry
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths
   localparam int OP_W  = 2;
   localparam int POS_W = 11;
   localparam int CP_W  = 21;
   localparam int LEN_W = 11;
   localparam int STS_W = 2;

   // Width for comparing positions against the count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // Status codes
   localparam logic [STS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STS_W-1:0] ST_BEYOND = 2'd2;

endpackage

// ===== rtl/clb_ram.sv =====
module clb_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/codepoint_line_buffer.sv =====
// Ordered codepoint store of CAPACITY entries held in one single-port-write,
// registered-read RAM, one request at a time. Insert at clamped position p
// with n stored entries walks the entries p..n-1 upward one per cycle;
// remove walks the entries from the clamped end e to n-1 down. Read,
// clear and a rejected insert skip the walk. The walk rate is set by the
// one RAM read and one RAM write each cycle. The next request is taken
// once the current one has placed its result in the output register,
// even while that result waits to be taken. There is no clearing pass
// after reset.
module codepoint_line_buffer
   import clb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [POS_W-1:0] req_position,
   input  logic [POS_W-1:0] req_end_position,
   input  logic [CP_W-1:0]  req_codepoint,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CP_W-1:0]  rsp_read_value,
   output logic [LEN_W-1:0] rsp_length,
   output logic [STS_W-1:0] rsp_status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_PUT,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  newcnt_ff, newcnt_in;
   logic [CNT_W-1:0]  gap_ff, gap_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] put_addr_ff, put_addr_in;
   logic [CP_W-1:0]   cp_ff, cp_in;
   logic              up_ff, up_in;
   logic              put_ff, put_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [STS_W-1:0]  status_ff, status_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [STS_W-1:0]  rsp_status_ff, rsp_status_in;

   // RAM port signals
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CP_W-1:0]   wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CP_W-1:0]   rd_data;

   // Clamped request bounds
   logic [CMP_W-1:0] pos_w, end_w, n_w;
   logic [CMP_W-1:0] p_clamp, e_clamp, s_clamp;
   logic [CNT_W-1:0] gap_req;
   logic             accept;

   clb_ram #(
      .WIDTH (CP_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_status     = rsp_status_ff;

   // Clamp positions to the current count
   always_comb begin
      pos_w   = CMP_W'(req_position);
      end_w   = CMP_W'(req_end_position);
      n_w     = CMP_W'(count_ff);
      p_clamp = (pos_w > n_w) ? n_w : pos_w;
      e_clamp = (end_w > n_w) ? n_w : end_w;
      s_clamp = (p_clamp > e_clamp) ? e_clamp : p_clamp;
      gap_req = CNT_W'(e_clamp - s_clamp);
   end

   // RAM access: pending shift write has priority over the final insert write
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = src_ff;
      if (state_ff == S_SHIFT) begin
         rd_en = 1'b1;
      end else if (accept && (req_opcode == OP_READ)) begin
         rd_en   = 1'b1;
         rd_addr = pos_w[ADDR_W-1:0];
      end
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data;
      end else begin
         wr_en   = (state_ff == S_PUT) && put_ff;
         wr_addr = put_addr_ff;
         wr_data = cp_ff;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      newcnt_in     = newcnt_ff;
      gap_in        = gap_ff;
      src_in        = src_ff;
      last_in       = last_ff;
      put_addr_in   = put_addr_ff;
      cp_in         = cp_ff;
      up_in         = up_ff;
      put_in        = put_ff;
      rd_ok_in      = rd_ok_ff;
      status_in     = status_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               newcnt_in   = count_ff;
               put_in      = 1'b0;
               rd_ok_in    = 1'b0;
               status_in   = ST_OK;
               cp_in       = req_codepoint;
               put_addr_in = p_clamp[ADDR_W-1:0];
               state_in    = S_PUT;
               case (req_opcode)
                  OP_INSERT: begin
                     if (n_w >= CMP_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        put_in    = 1'b1;
                        newcnt_in = count_ff + 1'b1;
                        up_in     = 1'b1;
                        src_in    = ADDR_W'(n_w - 1'b1);
                        last_in   = p_clamp[ADDR_W-1:0];
                        if (p_clamp != n_w) begin
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     newcnt_in = count_ff - gap_req;
                     gap_in    = gap_req;
                     up_in     = 1'b0;
                     src_in    = e_clamp[ADDR_W-1:0];
                     last_in   = ADDR_W'(n_w - 1'b1);
                     if ((gap_req != '0) && (e_clamp != n_w)) begin
                        state_in = S_SHIFT;
                     end
                  end
                  OP_READ: begin
                     if (pos_w < n_w) begin
                        rd_ok_in = 1'b1;
                     end else begin
                        status_in = ST_BEYOND;
                     end
                  end
                  default: begin
                     newcnt_in = '0;
                  end
               endcase
            end
         end

         // One entry moved per cycle; write lands in the cycle after its read
         S_SHIFT: begin
            pend_in = 1'b1;
            if (up_ff) begin
               pend_addr_in = src_ff + 1'b1;
               src_in       = src_ff - 1'b1;
            end else begin
               pend_addr_in = ADDR_W'(CNT_W'(src_ff) - gap_ff);
               src_in       = src_ff + 1'b1;
            end
            if (src_ff == last_ff) begin
               state_in = S_PUT;
            end
         end

         // Wait out the last shift write, then place any new entry and update the count
         S_PUT: begin
            if (!pend_ff) begin
               count_in = newcnt_ff;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_ok_ff ? rd_data : '0;
               rsp_length_in = LEN_W'(CMP_W'(count_ff));
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      newcnt_ff     <= newcnt_in;
      gap_ff        <= gap_in;
      src_ff        <= src_in;
      last_ff       <= last_in;
      put_addr_ff   <= put_addr_in;
      cp_ff         <= cp_in;
      up_ff         <= up_in;
      put_ff        <= put_in;
      rd_ok_ff      <= rd_ok_in;
      status_ff     <= status_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
